// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== design/cfc_pkg.sv =====
// ----------------------------------------------------------------------------
// Command frame checker package
// Character codes, result codes and sizes shared by the design files.
// ----------------------------------------------------------------------------
package cfc_pkg;

	localparam int unsigned DEPTH = 7;
	localparam int unsigned CNT_W = 3;

	localparam logic [7:0] CH_OPEN  = 8'h23;
	localparam logic [7:0] CH_CLOSE = 8'h21;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_FOUR  = 8'h34;
	localparam logic [7:0] CH_B     = 8'h42;
	localparam logic [7:0] CH_L     = 8'h4C;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_R     = 8'h52;
	localparam logic [7:0] CH_V     = 8'h56;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_SYNTAX   = 2'd1,
		ST_MISMATCH = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		KIND_BUTTON = 2'd0,
		KIND_LED    = 2'd1,
		KIND_ADC    = 2'd2
	} kind_t;

endpackage

// ===== design/cfc_if.sv =====
// ----------------------------------------------------------------------------
// Command frame checker channels
// Byte input channel and result output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface cfc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfc_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [1:0] kind;
	logic [2:0] channel;
	logic       led_write;
	logic       led_level;
	logic       adc_scaled;
	logic [7:0] checksum_value;

	modport source (output valid, output status, output kind, output channel,
		output led_write, output led_level, output adc_scaled,
		output checksum_value, input ready);
	modport sink   (input valid, input status, input kind, input channel,
		input led_write, input led_level, input adc_scaled,
		input checksum_value, output ready);
endinterface

// ===== design/command_frame_checker.sv =====
// ----------------------------------------------------------------------------
// Command frame checker
// Collects framed text commands byte by byte and reports one checked result
// for each closing '!'.
// ----------------------------------------------------------------------------
// Usage:
//   rx  : byte channel, one received ASCII character per transaction.
//   res : result channel, one transaction per '!' that closes an open frame,
//         carrying status, decoded command fields and the frame's checksum.
//   A '#' opens or restarts a frame; bytes outside a frame are dropped.
//   Up to seven body bytes are held; a longer body is a syntax error.
// Path: a byte is registered at the input, then judged and written to
//   the result register; a closing '!' passes through both registers and
//   can wait in the input register while the result register is full.
// Throughput: one byte per cycle unless a '!' waits on a full result register,
//   set by the single judge stage between the input and result registers.
// Reset: arst_n clears the open-frame flag, the byte count, the overflow
//   flag and both valid flags; the held bytes keep their contents.
// Stall: a pending result waits in the output register; bytes that give no
//   result keep flowing, and a closing '!' waits in the input register, with
//   rx.ready held low, until the result register is free.
// ----------------------------------------------------------------------------
module command_frame_checker (
	input  logic                clk,
	input  logic                arst_n,
	cfc_byte_if.sink            rx,
	cfc_result_if.source        res
);
	import cfc_pkg::*;

	logic             valid_s1;
	logic [7:0]       byte_s1;

	logic             in_frame_q;
	logic [CNT_W-1:0] count_q;
	logic             overflow_q;
	logic [7:0]       frame_q [DEPTH];

	logic             res_valid_q;
	status_t          status_q;
	kind_t            kind_q;
	logic [2:0]       channel_q;
	logic             led_write_q;
	logic             led_level_q;
	logic             adc_scaled_q;
	logic [7:0]       checksum_q;

	logic             is_open;
	logic             is_close;
	logic             out_free;
	logic             fire_s1;

	status_t          status_d;
	kind_t            kind_d;
	logic [2:0]       channel_d;
	logic             led_write_d;
	logic             led_level_d;
	logic             adc_scaled_d;
	logic [7:0]       checksum_d;

	assign is_open  = (byte_s1 == CH_OPEN);
	assign is_close = in_frame_q && !is_open && (byte_s1 == CH_CLOSE);
	assign out_free = !res_valid_q || res.ready;
	assign fire_s1  = valid_s1 && (!is_close || out_free);
	assign rx.ready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			count_q    <= '0;
			overflow_q <= 1'b0;
		end else if (fire_s1) begin
			if (is_open) begin
				in_frame_q <= 1'b1;
				count_q    <= '0;
				overflow_q <= 1'b0;
			end else if (is_close) begin
				in_frame_q <= 1'b0;
				count_q    <= '0;
				overflow_q <= 1'b0;
			end else if (in_frame_q) begin
				if (count_q < CNT_W'(DEPTH)) begin
					count_q <= count_q + CNT_W'(1);
				end else begin
					overflow_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && in_frame_q && !is_open && !is_close
				&& (count_q < CNT_W'(DEPTH))) begin
			frame_q[count_q] <= byte_s1;
		end
	end

	// judge the held body
	always_comb begin
		logic       long_cmd;
		logic       len_ok;
		logic       cmd_ok;
		logic       dig_ok;
		logic [7:0] d0;
		logic [7:0] d1;
		logic [7:0] d2;
		logic [9:0] val;
		logic [7:0] sum;
		logic       ch_ok;

		long_cmd = (count_q == CNT_W'(6));
		len_ok   = !overflow_q && ((count_q == CNT_W'(5)) || long_cmd);
		ch_ok    = (frame_q[1] >= CH_ONE) && (frame_q[1] <= CH_FOUR);

		kind_d       = KIND_BUTTON;
		channel_d    = '0;
		led_write_d  = 1'b0;
		led_level_d  = 1'b0;
		adc_scaled_d = 1'b0;
		cmd_ok       = 1'b0;

		if (frame_q[0] == CH_B && !long_cmd && ch_ok) begin
			kind_d    = KIND_BUTTON;
			channel_d = 3'(frame_q[1] - CH_ZERO);
			cmd_ok    = 1'b1;
		end else if (frame_q[0] == CH_L && ch_ok) begin
			kind_d    = KIND_LED;
			channel_d = 3'(frame_q[1] - CH_ZERO);
			if (!long_cmd) begin
				cmd_ok = 1'b1;
			end else if (frame_q[2] == CH_ZERO || frame_q[2] == CH_ONE) begin
				led_write_d = 1'b1;
				led_level_d = frame_q[2][0];
				cmd_ok      = 1'b1;
			end
		end else if (frame_q[0] == CH_A && !long_cmd
				&& (frame_q[1] == CH_R || frame_q[1] == CH_V)) begin
			kind_d       = KIND_ADC;
			adc_scaled_d = (frame_q[1] == CH_V);
			cmd_ok       = 1'b1;
		end

		d0 = long_cmd ? frame_q[3] : frame_q[2];
		d1 = long_cmd ? frame_q[4] : frame_q[3];
		d2 = long_cmd ? frame_q[5] : frame_q[4];
		dig_ok = (d0 >= CH_ZERO) && (d0 <= CH_NINE)
			&& (d1 >= CH_ZERO) && (d1 <= CH_NINE)
			&& (d2 >= CH_ZERO) && (d2 <= CH_NINE);
		val = 10'(d0[3:0]) * 10'd100 + 10'(d1[3:0]) * 10'd10 + 10'(d2[3:0]);
		sum = frame_q[0] + frame_q[1] + (long_cmd ? frame_q[2] : 8'd0);

		checksum_d = val[7:0];
		if (len_ok && cmd_ok && dig_ok && (val <= 10'd255)) begin
			status_d = (sum == val[7:0]) ? ST_OK : ST_MISMATCH;
		end else begin
			status_d     = ST_SYNTAX;
			kind_d       = KIND_BUTTON;
			channel_d    = '0;
			led_write_d  = 1'b0;
			led_level_d  = 1'b0;
			adc_scaled_d = 1'b0;
			checksum_d   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire_s1 && is_close) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && is_close) begin
			status_q     <= status_d;
			kind_q       <= kind_d;
			channel_q    <= channel_d;
			led_write_q  <= led_write_d;
			led_level_q  <= led_level_d;
			adc_scaled_q <= adc_scaled_d;
			checksum_q   <= checksum_d;
		end
	end

	assign res.valid          = res_valid_q;
	assign res.status         = status_q;
	assign res.kind           = kind_q;
	assign res.channel        = channel_q;
	assign res.led_write      = led_write_q;
	assign res.led_level      = led_level_q;
	assign res.adc_scaled     = adc_scaled_q;
	assign res.checksum_value = checksum_q;

endmodule

// ===== design/cfc_checker.sv =====
// ----------------------------------------------------------------------------
// Command frame checker assertions
// Port-level checks on the result channel, bound into command_frame_checker.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cfc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic [1:0] status,
	input logic [1:0] kind,
	input logic [2:0] channel,
	input logic       led_write,
	input logic       led_level,
	input logic       adc_scaled,
	input logic [7:0] checksum_value
);
	import cfc_pkg::*;

	`ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(status))
	`ASSERT_NOW(a_syntax_clear, res_valid && status == ST_SYNTAX, kind == KIND_BUTTON && channel == 3'd0 && !led_write && !led_level && !adc_scaled && checksum_value == 8'd0)
	`ASSERT_NOW(a_adc_fields, res_valid && kind == KIND_ADC, channel == 3'd0 && !led_write)
	`ASSERT_NOW(a_led_fields, res_valid && kind != KIND_LED, !led_write && !led_level)
	`ASSERT_NOW(a_chan_range, res_valid && kind != KIND_ADC && status != ST_SYNTAX, channel >= 3'd1 && channel <= 3'd4 && !adc_scaled)

endmodule

bind command_frame_checker cfc_checker u_cfc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.res_valid      (res.valid),
	.res_ready      (res.ready),
	.status         (res.status),
	.kind           (res.kind),
	.channel        (res.channel),
	.led_write      (res.led_write),
	.led_level      (res.led_level),
	.adc_scaled     (res.adc_scaled),
	.checksum_value (res.checksum_value)
);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Command frame checker testbench
// Walks a short table of hand-made frames, then a long run of random frames
// with random content, corruptions, restarts and noise between frames. Every
// byte accepted goes through a local frame judge; each result transaction is
// compared field by field with the oldest outstanding verdict.
// ----------------------------------------------------------------------------
module tb;
	import cfc_pkg::*;

	localparam int ITEMS = 1700;
	localparam int LIMIT = 400000;

	typedef struct packed {
		status_t    status;
		kind_t      kind;
		logic [2:0] channel;
		logic       led_write;
		logic       led_level;
		logic       adc_scaled;
		logic [7:0] checksum_value;
	} verdict_t;

	// '~' stands for a NUL byte in the text column
	typedef struct {
		string      text;
		bit         typed;
		status_t    st;
		kind_t      kd;
		logic [2:0] ch;
		logic       wr;
		logic       lvl;
		logic       sc;
		logic [7:0] val;
	} stim_row_t;

	stim_row_t directed_rows [16] = '{
		'{"#B1115!",          1, ST_OK,       KIND_BUTTON, 1, 0, 0, 0, 115},
		'{"#B4000!",          1, ST_MISMATCH, KIND_BUTTON, 4, 0, 0, 0, 0},
		'{"#L1125!",          1, ST_OK,       KIND_LED,    1, 0, 0, 0, 125},
		'{"#L41177!",         1, ST_OK,       KIND_LED,    4, 1, 1, 0, 177},
		'{"#L10173!",         1, ST_OK,       KIND_LED,    1, 1, 0, 0, 173},
		'{"#AR147!",          1, ST_OK,       KIND_ADC,    0, 0, 0, 0, 147},
		'{"#AV255!",          1, ST_MISMATCH, KIND_ADC,    0, 0, 0, 1, 255},
		'{"#AV256!",          1, ST_SYNTAX,   KIND_BUTTON, 0, 0, 0, 0, 0},
		'{"#B1115X!",         1, ST_SYNTAX,   KIND_BUTTON, 0, 0, 0, 0, 0},
		'{"#L4123456789!",    1, ST_SYNTAX,   KIND_BUTTON, 0, 0, 0, 0, 0},
		'{"!\377~#B2#B2116!", 1, ST_OK,       KIND_BUTTON, 2, 0, 0, 0, 116},
		'{"#!",               1, ST_SYNTAX,   KIND_BUTTON, 0, 0, 0, 0, 0},
		'{"#\377~\377~\377!", 1, ST_SYNTAX,   KIND_BUTTON, 0, 0, 0, 0, 0},
		'{"#L31175!",         0, ST_OK,       KIND_BUTTON, 0, 0, 0, 0, 0},
		'{"#AR14!",           0, ST_OK,       KIND_BUTTON, 0, 0, 0, 0, 0},
		'{"#L2099!",          0, ST_OK,       KIND_BUTTON, 0, 0, 0, 0, 0}
	};

	logic clk;
	logic arst_n;

	cfc_byte_if   rx ();
	cfc_result_if res ();

	command_frame_checker dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.res    (res)
	);

	logic        frame_open;
	int unsigned held_count;
	logic [7:0]  held_bytes [DEPTH];
	logic        spilled;

	verdict_t pending_verdicts[$];
	int       faults;
	int       live_bytes;
	int       cycles;
	int       stall_left;
	bit       calm;
	bit       steady;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic bit is_channel_char(input logic [7:0] c);
		return c >= CH_ONE && c <= CH_FOUR;
	endfunction

	function automatic verdict_t judge_frame();
		verdict_t    r;
		kind_t       kd;
		logic [2:0]  ch;
		logic        wr, lvl, sc, ok;
		int unsigned m, v, s, i;
		r = '0;
		r.status = ST_SYNTAX;
		kd = KIND_BUTTON;
		ch = '0;
		wr = 1'b0;
		lvl = 1'b0;
		sc = 1'b0;
		ok = 1'b0;
		if (spilled || held_count < 5 || held_count > 6)
			return r;
		m = held_count - 3;
		if (held_bytes[0] == CH_B && m == 2 && is_channel_char(held_bytes[1])) begin
			ch = 3'(held_bytes[1] - CH_ZERO);
			ok = 1'b1;
		end else if (held_bytes[0] == CH_L && is_channel_char(held_bytes[1])) begin
			kd = KIND_LED;
			ch = 3'(held_bytes[1] - CH_ZERO);
			if (m == 2) begin
				ok = 1'b1;
			end else if (held_bytes[2] == CH_ZERO || held_bytes[2] == CH_ONE) begin
				wr = 1'b1;
				lvl = held_bytes[2][0];
				ok = 1'b1;
			end
		end else if (held_bytes[0] == CH_A && m == 2 &&
				(held_bytes[1] == CH_R || held_bytes[1] == CH_V)) begin
			kd = KIND_ADC;
			sc = (held_bytes[1] == CH_V);
			ok = 1'b1;
		end
		if (!ok)
			return r;
		for (i = m; i < held_count; i++)
			if (held_bytes[i] < CH_ZERO || held_bytes[i] > CH_NINE)
				return r;
		v = 100 * (held_bytes[m] - CH_ZERO) + 10 * (held_bytes[m + 1] - CH_ZERO)
			+ (held_bytes[m + 2] - CH_ZERO);
		if (v > 255)
			return r;
		s = 0;
		for (i = 0; i < m; i++)
			s = (s + held_bytes[i]) & 8'hFF;
		if (s == v)
			r.status = ST_OK;
		else
			r.status = ST_MISMATCH;
		r.kind = kd;
		r.channel = ch;
		r.led_write = wr;
		r.led_level = lvl;
		r.adc_scaled = sc;
		r.checksum_value = 8'(v);
		return r;
	endfunction

	function automatic bit absorb_byte(input logic [7:0] b, output verdict_t r);
		r = '0;
		if (b == CH_OPEN) begin
			frame_open = 1'b1;
			held_count = 0;
			spilled = 1'b0;
			return 1'b0;
		end
		if (!frame_open)
			return 1'b0;
		if (b == CH_CLOSE) begin
			r = judge_frame();
			frame_open = 1'b0;
			held_count = 0;
			spilled = 1'b0;
			return 1'b1;
		end
		if (held_count < DEPTH) begin
			held_bytes[held_count] = b;
			held_count++;
		end else begin
			spilled = 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic send_byte(input logic [7:0] b, input bit typed, input verdict_t typed_res);
		verdict_t r;
		if (!calm && !steady && $urandom_range(0, 5) == 0) begin
			rx.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		rx.valid <= 1'b1;
		rx.rx_byte <= b;
		@(posedge clk);
		while (!rx.ready)
			@(posedge clk);
		if (b == CH_OPEN || frame_open)
			live_bytes++;
		if (absorb_byte(b, r))
			pending_verdicts.push_back(typed ? typed_res : r);
	endtask

	task automatic wait_drained();
		rx.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_verdicts.size() != 0);
	endtask

	task automatic check_result();
		verdict_t want;
		if (pending_verdicts.size() == 0) begin
			faults++;
			if (faults <= 10)
				$display("unexpected result: st=%0d kd=%0d ch=%0d ck=%0d",
					res.status, res.kind, res.channel, res.checksum_value);
			return;
		end
		want = pending_verdicts.pop_front();
		if (res.status !== want.status || res.kind !== want.kind ||
				res.channel !== want.channel || res.led_write !== want.led_write ||
				res.led_level !== want.led_level || res.adc_scaled !== want.adc_scaled ||
				res.checksum_value !== want.checksum_value) begin
			faults++;
			if (faults <= 10) begin
				$display("mismatch: exp st=%0d kd=%0d ch=%0d wr=%0b lv=%0b sc=%0b ck=%0d",
					want.status, want.kind, want.channel, want.led_write,
					want.led_level, want.adc_scaled, want.checksum_value);
				$display("          got st=%0d kd=%0d ch=%0d wr=%0b lv=%0b sc=%0b ck=%0d",
					res.status, res.kind, res.channel, res.led_write,
					res.led_level, res.adc_scaled, res.checksum_value);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (res.valid && res.ready)
				check_result();
			if (stall_left != 0) begin
				res.ready <= 1'b0;
				stall_left <= stall_left - 1;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				res.ready <= 1'b0;
				stall_left <= $urandom_range(0, 8);
			end else begin
				res.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		logic [7:0] frame[$];
		logic [7:0] c;
		verdict_t   want;
		int         sel, sum, val, len, pos, k, i;
		rx.valid = 1'b0;
		rx.rx_byte = '0;
		arst_n = 1'b0;
		live_bytes = 0;
		calm = 1'b0;
		steady = 1'b0;
		frame_open = 1'b0;
		held_count = 0;
		spilled = 1'b0;
		for (i = 0; i < DEPTH; i++)
			held_bytes[i] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (k = 0; k < $size(directed_rows); k++) begin
			want = '0;
			want.status = directed_rows[k].st;
			want.kind = directed_rows[k].kd;
			want.channel = directed_rows[k].ch;
			want.led_write = directed_rows[k].wr;
			want.led_level = directed_rows[k].lvl;
			want.adc_scaled = directed_rows[k].sc;
			want.checksum_value = directed_rows[k].val;
			len = directed_rows[k].text.len();
			for (i = 0; i < len; i++) begin
				c = directed_rows[k].text[i];
				if (c == "~")
					c = 8'h00;
				send_byte(c, directed_rows[k].typed && i == len - 1, want);
			end
		end
		wait_drained();

		while (live_bytes < ITEMS) begin
			calm = (live_bytes > ITEMS - 250);
			steady = ($urandom_range(0, 5) == 0);
			frame.delete();
			if ($urandom_range(0, 4) == 0) begin
				repeat ($urandom_range(1, 4)) begin
					c = 8'($urandom_range(0, 255));
					frame.push_back(c == CH_OPEN ? CH_CLOSE : c);
				end
			end
			frame.push_back(CH_OPEN);
			sel = $urandom_range(0, 4);
			case (sel)
				0: begin
					frame.push_back(CH_B);
					frame.push_back(CH_ZERO + 8'($urandom_range(1, 4)));
				end
				1: begin
					frame.push_back(CH_L);
					frame.push_back(CH_ZERO + 8'($urandom_range(1, 4)));
				end
				2: begin
					frame.push_back(CH_L);
					frame.push_back(CH_ZERO + 8'($urandom_range(1, 4)));
					frame.push_back(CH_ZERO + 8'($urandom_range(0, 1)));
				end
				default: begin
					frame.push_back(CH_A);
					frame.push_back(sel == 3 ? CH_R : CH_V);
				end
			endcase
			sum = 0;
			for (i = 1; i < frame.size(); i++)
				if (i > frame.size() - (sel == 2 ? 4 : 3))
					sum = (sum + frame[i]) & 8'hFF;
			val = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 255) : sum;
			if ($urandom_range(0, 11) == 0) begin
				repeat (3)
					frame.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
			end else begin
				frame.push_back(CH_ZERO + 8'(val / 100));
				frame.push_back(CH_ZERO + 8'((val / 10) % 10));
				frame.push_back(CH_ZERO + 8'(val % 10));
			end
			frame.push_back(CH_CLOSE);
			len = frame.size();
			case ($urandom_range(0, 11))
				0: frame[len - 1 - $urandom_range(1, 5)] = 8'($urandom_range(0, 255));
				1: frame.insert(len - 1 - $urandom_range(0, 5), 8'($urandom_range(0, 255)));
				2: frame.delete(len - 1 - $urandom_range(1, 5));
				3: repeat ($urandom_range(1, 6))
					frame.insert(len - 1, CH_ZERO + 8'($urandom_range(0, 9)));
				4: frame.delete(len - 1);
				5: begin
					pos = len - 1 - $urandom_range(5, 6);
					repeat ($urandom_range(0, 3))
						frame.insert(pos, 8'($urandom_range(0, 255)));
					frame.insert(pos, CH_OPEN);
				end
				default: ;
			endcase
			foreach (frame[i])
				send_byte(frame[i], 1'b0, '0);
			if ($urandom_range(0, 39) == 0)
				wait_drained();
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (faults == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
